### hdl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg: shared types and constants of the task priority table
// Request and status codes, sequencer states and the control and flag
// structs that pass between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

  // Default geometry of the table.
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ID_BITS_DEF     = 16;

  // Width of a priority value, fixed by the request format.
  localparam int PRIO_BITS = 32;

  // Request kinds carried with each input item.
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_EDIT   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_EXEC   = 2'd3
  } tpt_req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } tpt_status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } tpt_state_e;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;   // start of a new request: drop all search results
    logic sample;  // an entry read from the table is present this cycle
  } tpt_scan_ctl_t;

  // Search results reported by the scan unit.
  typedef struct packed {
    logic match_found;  // an entry with the requested task id exists
    logic free_found;   // at least one unused slot exists
    logic best_found;   // at least one valid entry exists
  } tpt_scan_flags_t;

endpackage : tpt_pkg

`default_nettype wire

### hdl/tpt_mem.sv
// ----------------------------------------------------------------------------
// tpt_mem: entry storage of the task priority table
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_mem #(
  parameter int DEPTH      = tpt_pkg::TABLE_DEPTH_DEF,
  parameter int WORD_BITS  = 1 + 2 * tpt_pkg::ID_BITS_DEF + tpt_pkg::PRIO_BITS,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WORD_BITS-1:0] wdata_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule : tpt_mem

`default_nettype wire

### hdl/tpt_scan.sv
// ----------------------------------------------------------------------------
// tpt_scan: shared compare unit of the task priority table
// Looks at one table entry per cycle and keeps the id match, the first free
// slot and the highest-priority entry seen so far.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_scan #(
  parameter int DEPTH   = tpt_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS = tpt_pkg::ID_BITS_DEF,
  localparam int AW     = $clog2(DEPTH),
  localparam int PB     = tpt_pkg::PRIO_BITS,
  localparam int WB     = 1 + 2 * ID_BITS + PB
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tpt_pkg::tpt_scan_ctl_t ctl_i,
  input  wire logic [AW-1:0]        ent_idx_i,
  input  wire logic [WB-1:0]        ent_word_i,
  input  wire logic [ID_BITS-1:0]   req_task_i,
  output tpt_pkg::tpt_scan_flags_t  flags_o,
  output logic      [AW-1:0]        match_idx_o,
  output logic      [ID_BITS-1:0]   match_user_o,
  output logic      [AW-1:0]        free_idx_o,
  output logic      [AW-1:0]        best_idx_o,
  output logic      [ID_BITS-1:0]   best_user_o
);

  logic                 ent_valid;
  logic [ID_BITS-1:0]   ent_task;
  logic [ID_BITS-1:0]   ent_user;
  logic [PB-1:0]        ent_prio;
  logic                 is_match;
  logic                 is_free;
  logic                 is_better;

  tpt_pkg::tpt_scan_flags_t flags_q, flags_d;
  logic [PB-1:0]      best_prio_q;
  logic [ID_BITS-1:0] best_task_q;

  // Unpack the entry word: valid, task, user, priority from the top down.
  assign ent_prio  = ent_word_i[PB-1:0];
  assign ent_user  = ent_word_i[PB+ID_BITS-1:PB];
  assign ent_task  = ent_word_i[PB+2*ID_BITS-1:PB+ID_BITS];
  assign ent_valid = ent_word_i[PB+2*ID_BITS];

  // One set of comparisons, applied to the entry at hand.
  always_comb begin
    is_match  = ctl_i.sample && ent_valid && (ent_task == req_task_i) &&
                !flags_q.match_found;
    is_free   = ctl_i.sample && !ent_valid && !flags_q.free_found;
    is_better = ctl_i.sample && ent_valid &&
                (!flags_q.best_found || (ent_prio > best_prio_q) ||
                 ((ent_prio == best_prio_q) && (ent_task > best_task_q)));
  end

  // Flag update: cleared at the start of each request.
  always_comb begin
    flags_d = flags_q;
    if (ctl_i.clear) begin
      flags_d = '0;
    end else begin
      if (is_match) begin
        flags_d.match_found = 1'b1;
      end
      if (is_free) begin
        flags_d.free_found = 1'b1;
      end
      if (is_better) begin
        flags_d.best_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // Payload of the search results.
  always_ff @(posedge clk_i) begin
    if (is_match) begin
      match_idx_o  <= ent_idx_i;
      match_user_o <= ent_user;
    end
    if (is_free) begin
      free_idx_o <= ent_idx_i;
    end
    if (is_better) begin
      best_idx_o  <= ent_idx_i;
      best_user_o <= ent_user;
      best_prio_q <= ent_prio;
      best_task_q <= ent_task;
    end
  end

  assign flags_o = flags_q;

endmodule : tpt_scan

`default_nettype wire

### hdl/task_priority_table.sv
// ----------------------------------------------------------------------------
// task_priority_table: indexed max-priority table of tasks
// Add, edit, remove and execute-top requests on a table of tasks held in
// one memory and searched by a shared compare unit, one entry per cycle.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata (low bit up)                tuser
//  s_axis   in   task_id, user_id, priority_req    req_type
//  m_axis   out  top_user                          status
//
// No new item is accepted until the previous one is through: the table is
// read one entry per cycle through the single memory read port, then a
// drain state empties the read register and a write state updates the entry
// and loads the result. After reset a clearing pass writes every slot once
// and marks it free; no item is accepted meanwhile.
// A result waits in an output register; the update stalls only if the
// previous result has not been taken yet.
// ----------------------------------------------------------------------------
`default_nettype none

module task_priority_table #(
  parameter int TABLE_DEPTH = tpt_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BITS     = tpt_pkg::ID_BITS_DEF,
  localparam int AW         = $clog2(TABLE_DEPTH),
  localparam int PB         = tpt_pkg::PRIO_BITS,
  localparam int WB         = 1 + 2 * ID_BITS + PB,
  localparam int S_DW       = ((2 * ID_BITS + PB + 7) / 8) * 8,
  localparam int M_DW       = ((ID_BITS + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // Request items.
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [S_DW-1:0] s_axis_tdata,  // task_id, user_id, priority_req
  input  wire logic [1:0]      s_axis_tuser,  // req_type
  // Result items.
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic      [M_DW-1:0] m_axis_tdata,  // top_user
  output logic      [1:0]      m_axis_tuser   // status
);

  tpt_pkg::tpt_state_e state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic                cnt_last;
  logic                sample_q;
  logic [AW-1:0]       idx_q;
  logic                s_hs;
  logic                out_free;

  tpt_pkg::tpt_req_e   req_q;
  logic [ID_BITS-1:0]  task_q;
  logic [ID_BITS-1:0]  user_q;
  logic [PB-1:0]       prio_q;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WB-1:0]        mem_wdata;
  logic [WB-1:0]        mem_rdata;

  tpt_pkg::tpt_scan_ctl_t   scan_ctl;
  tpt_pkg::tpt_scan_flags_t scan_flags;
  logic [AW-1:0]            match_idx;
  logic [ID_BITS-1:0]       match_user;
  logic [AW-1:0]            free_idx;
  logic [AW-1:0]            best_idx;
  logic [ID_BITS-1:0]       best_user;

  logic                 res_load;
  tpt_pkg::tpt_status_e res_status;
  logic [ID_BITS-1:0]   res_user;

  logic                 out_valid_q;
  tpt_pkg::tpt_status_e out_status_q;
  logic [ID_BITS-1:0]   out_user_q;

  assign s_hs     = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign cnt_last = (cnt_q == AW'(TABLE_DEPTH - 1));

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpt_pkg::ST_CLEAR: if (cnt_last) state_d = tpt_pkg::ST_IDLE;
      tpt_pkg::ST_IDLE:  if (s_hs) state_d = tpt_pkg::ST_SCAN;
      tpt_pkg::ST_SCAN:  if (cnt_last) state_d = tpt_pkg::ST_DRAIN;
      tpt_pkg::ST_DRAIN: state_d = tpt_pkg::ST_WRITE;
      tpt_pkg::ST_WRITE: if (out_free) state_d = tpt_pkg::ST_IDLE;
      default:           state_d = tpt_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer outputs: entry counter, handshake and scan control.
  always_comb begin
    cnt_d           = cnt_q;
    s_axis_tready   = 1'b0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.sample = sample_q;
    unique case (state_q) inside
      tpt_pkg::ST_CLEAR, tpt_pkg::ST_SCAN: begin
        cnt_d = cnt_last ? '0 : cnt_q + AW'(1);
      end
      tpt_pkg::ST_IDLE: begin
        s_axis_tready  = 1'b1;
        scan_ctl.clear = s_hs;
        cnt_d          = '0;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tpt_pkg::ST_CLEAR;
      cnt_q    <= '0;
      sample_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sample_q <= (state_q == tpt_pkg::ST_SCAN);
    end
  end

  // Index of the entry arriving from the memory read register.
  always_ff @(posedge clk_i) begin
    idx_q <= cnt_q;
  end

  // Capture the request fields.
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      req_q  <= tpt_pkg::tpt_req_e'(s_axis_tuser);
      task_q <= s_axis_tdata[ID_BITS-1:0];
      user_q <= s_axis_tdata[2*ID_BITS-1:ID_BITS];
      prio_q <= s_axis_tdata[2*ID_BITS+PB-1:2*ID_BITS];
    end
  end

  // Table update and result, decided once the scan is complete; the clearing pass writes every slot free.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = cnt_q;
    mem_wdata  = '0;
    res_load   = 1'b0;
    res_status = tpt_pkg::STAT_OK;
    res_user   = '0;
    if (state_q == tpt_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
    end else if ((state_q == tpt_pkg::ST_WRITE) && out_free) begin
      res_load = 1'b1;
      case (req_q)
        tpt_pkg::REQ_ADD: begin
          mem_wdata = {1'b1, task_q, user_q, prio_q};
          if (scan_flags.match_found) begin
            mem_we    = 1'b1;
            mem_waddr = match_idx;
          end else if (scan_flags.free_found) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx;
          end else begin
            res_status = tpt_pkg::STAT_FULL;
          end
        end
        tpt_pkg::REQ_EDIT: begin
          mem_wdata = {1'b1, task_q, match_user, prio_q};
          mem_waddr = match_idx;
          if (scan_flags.match_found) begin
            mem_we = 1'b1;
          end else begin
            res_status = tpt_pkg::STAT_NOT_FOUND;
          end
        end
        tpt_pkg::REQ_REMOVE: begin
          mem_waddr = match_idx;
          if (scan_flags.match_found) begin
            mem_we = 1'b1;
          end else begin
            res_status = tpt_pkg::STAT_NOT_FOUND;
          end
        end
        default: begin
          mem_waddr = best_idx;
          if (scan_flags.best_found) begin
            mem_we   = 1'b1;
            res_user = best_user;
          end else begin
            res_status = tpt_pkg::STAT_EMPTY;
          end
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_status_q <= res_status;
      out_user_q   <= res_user;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DW'(out_user_q);
  assign m_axis_tuser  = out_status_q;

  // Entry storage.
  tpt_mem #(
    .DEPTH     (TABLE_DEPTH),
    .WORD_BITS (WB)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cnt_q),
    .rdata_o (mem_rdata)
  );

  // Shared compare unit.
  tpt_scan #(
    .DEPTH   (TABLE_DEPTH),
    .ID_BITS (ID_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .ent_idx_i    (idx_q),
    .ent_word_i   (mem_rdata),
    .req_task_i   (task_q),
    .flags_o      (scan_flags),
    .match_idx_o  (match_idx),
    .match_user_o (match_user),
    .free_idx_o   (free_idx),
    .best_idx_o   (best_idx),
    .best_user_o  (best_user)
  );

endmodule : task_priority_table

`default_nettype wire
